@@ sv/rec_pkg.sv @@
// Shared types, widths and codes for the rotary encoder with debounced button.
package rec_pkg;

  // Button history depth in ticks.
  localparam int HISTORY_BITS = 8;

  localparam int POS_W      = 32;
  localparam int CNT_W      = 32;
  localparam int LIMIT_W    = 4;
  localparam int MASK_W     = 8;
  localparam int ACC_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);
  localparam logic [MASK_W-1:0]  MASK_RESET  = MASK_W'(15);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEGLITCH_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK    = CFG_IDX_W'(1);

  // Item operations; the fourth code is unused and changes nothing.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_POS = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // Update strobes from the top level to the state holders.
  typedef struct packed {
    logic step;
    logic tick;
    logic clear;
  } upd_ctl_t;

  // Button-side status.
  typedef struct packed {
    logic             pressed;
    logic [CNT_W-1:0] press_count;
    logic [CNT_W-1:0] hold_ticks;
  } btn_stat_t;

endpackage

@@ sv/rec_in_if.sv @@
// Input channel interface: operation and raw pin samples.
interface rec_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic                             level_a;
  logic                             level_b;
  logic                             level_button;
  logic signed [rec_pkg::POS_W-1:0] new_position;

  modport source (
    output valid, opcode, level_a, level_b, level_button, new_position,
    input  ready
  );
  modport sink (
    input  valid, opcode, level_a, level_b, level_button, new_position,
    output ready
  );
endinterface

@@ sv/rec_out_if.sv @@
// Output channel interface: position and button status.
interface rec_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rec_pkg::POS_W-1:0] position;
  logic [rec_pkg::CNT_W-1:0]        press_count;
  logic                             pressed;
  logic [rec_pkg::CNT_W-1:0]        hold_ticks;
  logic                             changed;

  modport source (
    output valid, position, press_count, pressed, hold_ticks, changed,
    input  ready
  );
  modport sink (
    input  valid, position, press_count, pressed, hold_ticks, changed,
    output ready
  );
endinterface

@@ sv/rec_integrator.sv @@
// Saturating up/down integrator with hysteresis for one encoder channel.
module rec_integrator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        raw_i,
  input  logic [rec_pkg::LIMIT_W-1:0] limit_i,
  output logic                        level_q_o,
  output logic                        level_d_o
);
  import rec_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d, lim, sum;
  logic                    level_q, level_d;

  // Count toward the sample, clamp at the bound and switch the level there.
  always_comb begin
    lim     = $signed(ACC_W'(limit_i));
    sum     = raw_i ? acc_q + ACC_W'(1) : acc_q - ACC_W'(1);
    acc_d   = sum;
    level_d = level_q;
    if (sum > lim) begin
      acc_d   = lim;
      level_d = 1'b1;
    end
    if (sum < -lim) begin
      acc_d   = -lim;
      level_d = 1'b0;
    end
  end

  // State advances only on a tick beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      level_q <= 1'b0;
    end else if (step_i) begin
      acc_q   <= acc_d;
      level_q <= level_d;
    end
  end

  assign level_q_o = level_q;
  assign level_d_o = level_d;

endmodule

@@ sv/rec_button.sv @@
// Button debounce history, press counter and hold counter.
module rec_button (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rec_pkg::upd_ctl_t          ctl_i,
  input  logic                       level_button_i,
  input  logic [rec_pkg::MASK_W-1:0] mask_i,
  output rec_pkg::btn_stat_t         stat_q_o,
  output rec_pkg::btn_stat_t         stat_d_o
);
  import rec_pkg::*;

  localparam int CmpW = (HISTORY_BITS > MASK_W) ? HISTORY_BITS : MASK_W;

  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [CmpW-1:0]         hist_c, mask_c;
  logic                    now_pressed;
  btn_stat_t               stat_q, stat_d;

  // Shift in the inverted pin level and test the selected history bits.
  always_comb begin
    hist_d      = {hist_q[HISTORY_BITS-2:0], ~level_button_i};
    hist_c      = CmpW'(hist_d);
    mask_c      = CmpW'(mask_i);
    now_pressed = ((hist_c & mask_c) == mask_c);
  end

  // Next counter values for tick and clear operations.
  always_comb begin
    stat_d = stat_q;
    if (ctl_i.tick) begin
      stat_d.pressed = now_pressed;
      if (now_pressed && !stat_q.pressed) begin
        stat_d.press_count = stat_q.press_count + CNT_W'(1);
      end
      if (!now_pressed) begin
        stat_d.hold_ticks = '0;
      end else if (stat_q.hold_ticks != '1) begin
        stat_d.hold_ticks = stat_q.hold_ticks + CNT_W'(1);
      end
    end else if (ctl_i.clear) begin
      stat_d.press_count = '0;
      stat_d.hold_ticks  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      stat_q <= '0;
    end else if (ctl_i.step) begin
      if (ctl_i.tick) begin
        hist_q <= hist_d;
      end
      stat_q <= stat_d;
    end
  end

  assign stat_q_o = stat_q;
  assign stat_d_o = stat_d;

endmodule

@@ sv/rotary_encoder_debounce_counter.sv @@
// Top level: rotary encoder position tracking with a debounced push button.
//
//  port    dir  beat contents
//  in_i    in   opcode, level_a, level_b, level_button, new_position
//  out_o   out  position, press_count, pressed, hold_ticks, changed
//  cfg_*   in   register index and data, written when cfg_we_i is high
//
// One item is accepted per cycle unless a stalled result holds the input register;
// each result passes through the input register and then the result register.
// Reset clears position, counters, history and integrators and loads the
// default deglitch limit (4) and button mask (15).
// A stalled result holds the input register; the next beat is still taken
// while the input register is free or is moving into the result register.
module rotary_encoder_debounce_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rec_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rec_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rec_in_if.sink                         in_i,
  rec_out_if.source                      out_o
);
  import rec_pkg::*;

  // Configuration registers.
  logic [LIMIT_W-1:0] limit_q;
  logic [MASK_W-1:0]  mask_q;

  // Input register.
  logic                    s1_valid_q;
  op_e                     s1_op_q;
  logic                    s1_a_q, s1_b_q, s1_btn_q;
  logic signed [POS_W-1:0] s1_pos_q;

  // Result register.
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_pos_q;
  btn_stat_t               out_stat_q;
  logic                    out_changed_q;

  logic                    advance, in_accept, int_step;
  upd_ctl_t                ctl;
  btn_stat_t               btn_q, btn_d;
  logic                    fa_q, fa_d, fb_q, fb_d;
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic                    changed;

  // Handshake: the input register moves on when the result register is free.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept  = in_i.valid && in_i.ready;

  assign ctl.step  = advance;
  assign ctl.tick  = (s1_op_q == OP_TICK);
  assign ctl.clear = (s1_op_q == OP_CLEAR);
  assign int_step  = advance && ctl.tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      mask_q  <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEGLITCH_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_BUTTON_MASK:    mask_q  <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= op_e'(in_i.opcode);
      s1_a_q   <= in_i.level_a;
      s1_b_q   <= in_i.level_b;
      s1_btn_q <= in_i.level_button;
      s1_pos_q <= in_i.new_position;
    end
  end

  rec_button u_button (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .level_button_i (s1_btn_q),
    .mask_i         (mask_q),
    .stat_q_o       (btn_q),
    .stat_d_o       (btn_d)
  );

  rec_integrator u_int_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (int_step),
    .raw_i     (s1_a_q),
    .limit_i   (limit_q),
    .level_q_o (fa_q),
    .level_d_o (fa_d)
  );

  rec_integrator u_int_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (int_step),
    .raw_i     (s1_b_q),
    .limit_i   (limit_q),
    .level_q_o (fb_q),
    .level_d_o (fb_d)
  );

  // Position: a falling edge of filtered A steps by one, direction from B.
  always_comb begin
    pos_d = pos_q;
    case (s1_op_q)
      OP_TICK: begin
        if (fa_q && !fa_d) begin
          pos_d = fb_d ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
        end
      end
      OP_SET_POS: pos_d = s1_pos_q;
      OP_CLEAR:   pos_d = '0;
      default:    pos_d = pos_q;
    endcase
  end

  assign changed = (pos_d != pos_q) || (btn_d.press_count != btn_q.press_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (advance) begin
      pos_q <= pos_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pos_q     <= pos_d;
      out_stat_q    <= btn_d;
      out_changed_q <= changed;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.position    = out_pos_q;
  assign out_o.press_count = out_stat_q.press_count;
  assign out_o.pressed     = out_stat_q.pressed;
  assign out_o.hold_ticks  = out_stat_q.hold_ticks;
  assign out_o.changed     = out_changed_q;

  // A nonzero hold count is only ever reported with the button pressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.hold_ticks != '0)) |-> out_o.pressed)
    else $error("hold count reported while button released");

  // A set-position beat loads the position register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_op_q == OP_SET_POS)) |=> (pos_q == $past(s1_pos_q)))
    else $error("set position not applied");

  // Input is only held off while an item waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked item");

  // Filtered levels move only on a tick beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !int_step |=> ($stable(fa_q) && $stable(fb_q)))
    else $error("filtered level changed without a tick");

endmodule
